// ===== rtl/oss_pkg.sv =====
package oss_pkg;

    // Block limits
    localparam int unsigned MAX_SAMPLES    = 4096;
    localparam int unsigned DAC_FULL_SCALE = 4095;

    // Field widths
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned AMP_W   = 12;
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned VAL_W   = 12;
    localparam int unsigned PHASE_W = 24;

    // Fixed-point constants: Q30 sine, pi/2 in Q30 (pi * 2^29)
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;
    localparam logic [22:0] QUARTER_ONE = 23'h40_0000;

    // Number of Taylor terms in the Horner chain
    localparam int unsigned HRN_TERMS = 7;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_AMPLITUDE    = 1'b0,
        CFG_SAMPLE_COUNT = 1'b1
    } t_cfg_index;

    // Item moving along the phase divider chain
    typedef struct packed {
        logic               valid;
        logic               err;
        logic [IDX_W-1:0]   rem;
        logic [PHASE_W-1:0] q;
    } t_div_item;

    // Item moving along the Horner chain
    typedef struct packed {
        logic        valid;
        logic        err;
        logic        neg;
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] t;
    } t_hrn_item;

endpackage

// ===== rtl/oss_div_cell.sv =====
// One restoring division step: one quotient bit of the phase per cell
module oss_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [oss_pkg::CNT_W-1:0]   i_n,
    input  oss_pkg::t_div_item          i_item,
    output oss_pkg::t_div_item          o_item
);

    logic [oss_pkg::CNT_W-1:0] w_r2;
    logic                      w_ge;
    logic [oss_pkg::CNT_W-1:0] w_diff;
    oss_pkg::t_div_item        n_item;
    oss_pkg::t_div_item        r_item;

    // Shift remainder, trial subtract
    always_comb begin
        w_r2   = {i_item.rem, 1'b0};
        w_ge   = (w_r2 >= i_n);
        w_diff = w_r2 - i_n;
        n_item       = i_item;
        n_item.rem   = w_ge ? w_diff[oss_pkg::IDX_W-1:0] : w_r2[oss_pkg::IDX_W-1:0];
        n_item.q     = {i_item.q[oss_pkg::PHASE_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item.valid <= n_item.valid;
        end
        if (i_en) begin
            r_item.err <= n_item.err;
            r_item.rem <= n_item.rem;
            r_item.q   <= n_item.q;
        end
    end

    assign o_item = r_item;

endmodule

// ===== rtl/oss_hrn_cell.sv =====
// One Horner step: t' = 1 - floor(floor(x2*t) / (2k(2k+1))), three stages
module oss_hrn_cell #(
    parameter int unsigned K = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  oss_pkg::t_hrn_item i_item,
    output oss_pkg::t_hrn_item o_item
);

    localparam int unsigned C_DIV   = 2 * K * (2 * K + 1);
    localparam logic [7:0]  C_DIV_W = 8'(C_DIV);
    // floor(2^32 / d): estimate is exact or one short for p < 2^32
    localparam logic [29:0] C_RECIP = 30'((64'd1 << 32) / C_DIV);

    oss_pkg::t_hrn_item r_a;
    oss_pkg::t_hrn_item r_b;
    oss_pkg::t_hrn_item r_c;
    logic [31:0]        r_p_a;
    logic [31:0]        r_p_b;
    logic [29:0]        r_qe_b;

    logic [62:0] w_prod_a;
    logic [61:0] w_prod_b;
    logic [37:0] w_qd;
    logic [31:0] w_rem;
    logic [30:0] w_term;
    logic [30:0] w_t;

    // Stage a: x2 * t
    assign w_prod_a = {31'd0, i_item.x2} * {32'd0, i_item.t};
    // Stage b: quotient estimate by reciprocal
    assign w_prod_b = {30'd0, r_p_a} * {32'd0, C_RECIP};
    // Stage c: correct estimate, form new t
    always_comb begin
        w_qd   = {8'd0, r_qe_b} * {30'd0, C_DIV_W};
        w_rem  = r_p_b - w_qd[31:0];
        w_term = (w_rem >= {24'd0, C_DIV_W}) ? ({1'b0, r_qe_b} + 31'd1) : {1'b0, r_qe_b};
        w_t    = (w_term >= oss_pkg::Q30_ONE) ? 31'd0 : (oss_pkg::Q30_ONE - w_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
        end else if (i_en) begin
            r_a.valid <= i_item.valid;
            r_b.valid <= r_a.valid;
            r_c.valid <= r_b.valid;
        end
        if (i_en) begin
            r_a.err <= i_item.err;
            r_a.neg <= i_item.neg;
            r_a.x   <= i_item.x;
            r_a.x2  <= i_item.x2;
            r_a.t   <= i_item.t;
            r_p_a   <= w_prod_a[61:30];
            r_b.err <= r_a.err;
            r_b.neg <= r_a.neg;
            r_b.x   <= r_a.x;
            r_b.x2  <= r_a.x2;
            r_b.t   <= r_a.t;
            r_p_b   <= r_p_a;
            r_qe_b  <= w_prod_b[61:32];
            r_c.err <= r_b.err;
            r_c.neg <= r_b.neg;
            r_c.x   <= r_b.x;
            r_c.x2  <= r_b.x2;
            r_c.t   <= w_t;
        end
    end

    assign o_item = r_c;

endmodule

// ===== rtl/offset_sine_sample_generator_unit.sv =====
// Offset sine sample generator: value = amplitude * (1 + sin(2*pi*index/N)),
// truncated and saturated at 4095 for a 12-bit DAC.
// Input channel: i_in_valid / o_in_ready with i_sample_index. Output channel:
// o_out_valid / i_out_ready with o_sample_value and o_index_error. An index
// not below the period (or a period of zero) gives index_error = 1, value 0.
// Registers: index 0 amplitude, index 1 sample_count (clamped to 4096),
// written through i_cfg_we / i_cfg_index / i_cfg_data; write only when idle.
// Throughput: one item per cycle unless the receiver stalls. The pipeline is an
// entry register, the 24-cell phase divider chain (one quotient bit per
// cell), two angle stages, seven 3-stage Horner cells and two output stages.
// Reset clears all valid bits and loads amplitude 2048 and sample_count 100;
// the block takes items as soon as reset is released.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops in the same cycle; nothing is lost or repeated.
module offset_sine_sample_generator_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [oss_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [oss_pkg::IDX_W-1:0]  i_sample_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [oss_pkg::VAL_W-1:0]  o_sample_value,
    output logic                       o_index_error
);

    localparam int unsigned C_DIV_CELLS = oss_pkg::PHASE_W;
    localparam int unsigned C_HRN_CELLS = oss_pkg::HRN_TERMS;

    logic [oss_pkg::AMP_W-1:0] r_amp;
    logic [oss_pkg::CNT_W-1:0] r_count;
    logic [oss_pkg::CNT_W-1:0] w_n;
    logic                      w_en;

    oss_pkg::t_div_item r_div_in;
    oss_pkg::t_div_item w_div [C_DIV_CELLS+1];
    oss_pkg::t_hrn_item w_hrn [C_HRN_CELLS+1];

    // Angle stage registers
    logic        r_x_valid;
    logic        r_x_err;
    logic        r_x_neg;
    logic [30:0] r_x;
    oss_pkg::t_hrn_item r_x2_item;

    // Final stage registers
    logic        r_m_valid;
    logic        r_m_err;
    logic        r_m_neg;
    logic [30:0] r_m;
    logic        r_out_valid;
    logic        r_out_err;
    logic [oss_pkg::VAL_W-1:0] r_out_val;

    logic [1:0]  w_quad;
    logic [21:0] w_r;
    logic [22:0] w_f;
    logic [53:0] w_xprod;
    logic [61:0] w_x2prod;
    logic [61:0] w_mprod;
    logic [31:0] w_mq;
    logic [30:0] w_m;
    logic [31:0] w_num;
    logic [43:0] w_vprod;
    logic [13:0] w_val;
    logic        w_in_err;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp   <= 12'd2048;
            r_count <= 13'd100;
        end else if (i_cfg_we) begin
            case (oss_pkg::t_cfg_index'(i_cfg_index))
                oss_pkg::CFG_AMPLITUDE:    r_amp   <= i_cfg_data[oss_pkg::AMP_W-1:0];
                oss_pkg::CFG_SAMPLE_COUNT: r_count <= i_cfg_data;
                default:                   r_count <= r_count;
            endcase
        end
    end

    // Effective period
    assign w_n = (r_count > oss_pkg::CNT_W'(oss_pkg::MAX_SAMPLES))
               ? oss_pkg::CNT_W'(oss_pkg::MAX_SAMPLES) : r_count;

    // Global advance: everything moves unless a result waits on a stalled receiver
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Entry stage: range check, remainder starts at the index (zero on an error)
    assign w_in_err = (w_n == '0) || ({1'b0, i_sample_index} >= w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_in.valid <= 1'b0;
        end else if (w_en) begin
            r_div_in.valid <= i_in_valid;
        end
        if (w_en) begin
            r_div_in.err <= w_in_err;
            r_div_in.rem <= w_in_err ? '0 : i_sample_index;
            r_div_in.q   <= '0;
        end
    end

    // Phase divider chain: (index << 24) / n
    assign w_div[0] = r_div_in;
    for (genvar g = 0; g < C_DIV_CELLS; g++) begin : g_div
        oss_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_n    (w_n),
            .i_item (w_div[g]),
            .o_item (w_div[g+1])
        );
    end

    // Quadrant fold and angle in radians
    always_comb begin
        w_quad  = w_div[C_DIV_CELLS].q[23:22];
        w_r     = w_div[C_DIV_CELLS].q[21:0];
        w_f     = w_quad[0] ? (oss_pkg::QUARTER_ONE - {1'b0, w_r}) : {1'b0, w_r};
        w_xprod = {31'd0, w_f} * {23'd0, oss_pkg::HALF_PI_Q30};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (w_en) begin
            r_x_valid <= w_div[C_DIV_CELLS].valid;
        end
        if (w_en) begin
            r_x_err <= w_div[C_DIV_CELLS].err;
            r_x_neg <= w_quad[1];
            r_x     <= w_xprod[52:22];
        end
    end

    // Square of the angle, Horner seed t = 1
    assign w_x2prod = {31'd0, r_x} * {31'd0, r_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x2_item.valid <= 1'b0;
        end else if (w_en) begin
            r_x2_item.valid <= r_x_valid;
        end
        if (w_en) begin
            r_x2_item.err <= r_x_err;
            r_x2_item.neg <= r_x_neg;
            r_x2_item.x   <= r_x;
            r_x2_item.x2  <= w_x2prod[61:30];
            r_x2_item.t   <= oss_pkg::Q30_ONE;
        end
    end

    // Horner chain, highest term first
    assign w_hrn[0] = r_x2_item;
    for (genvar h = 0; h < C_HRN_CELLS; h++) begin : g_hrn
        oss_hrn_cell #(
            .K(C_HRN_CELLS - h)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_item (w_hrn[h]),
            .o_item (w_hrn[h+1])
        );
    end

    // |sin| = x * t, clamped to one
    always_comb begin
        w_mprod = {31'd0, w_hrn[C_HRN_CELLS].x} * {31'd0, w_hrn[C_HRN_CELLS].t};
        w_mq    = w_mprod[61:30];
        w_m     = (w_mq > {1'b0, oss_pkg::Q30_ONE}) ? oss_pkg::Q30_ONE : w_mq[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_hrn[C_HRN_CELLS].valid;
        end
        if (w_en) begin
            r_m_err <= w_hrn[C_HRN_CELLS].err;
            r_m_neg <= w_hrn[C_HRN_CELLS].neg;
            r_m     <= w_m;
        end
    end

    // Offset, scale by amplitude, saturate
    always_comb begin
        w_num   = r_m_neg ? ({1'b0, oss_pkg::Q30_ONE} - {1'b0, r_m})
                          : ({1'b0, oss_pkg::Q30_ONE} + {1'b0, r_m});
        w_vprod = {32'd0, r_amp} * {12'd0, w_num};
        w_val   = w_vprod[43:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_m_valid;
        end
        if (w_en) begin
            r_out_err <= r_m_err;
            if (r_m_err) begin
                r_out_val <= '0;
            end else if (w_val > 14'(oss_pkg::DAC_FULL_SCALE)) begin
                r_out_val <= oss_pkg::VAL_W'(oss_pkg::DAC_FULL_SCALE);
            end else begin
                r_out_val <= w_val[oss_pkg::VAL_W-1:0];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_val;
    assign o_index_error  = r_out_err;

    // An index error always comes out with a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_index_error |-> o_sample_value == '0)
        else $error("index error with non-zero value");

    // Divider remainder stays below the period for in-range items
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div[C_DIV_CELLS].valid && !w_div[C_DIV_CELLS].err
        |-> {1'b0, w_div[C_DIV_CELLS].rem} < w_n)
        else $error("divider remainder out of range");

    // Folded angle never exceeds pi/2
    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_valid |-> r_x <= oss_pkg::HALF_PI_Q30)
        else $error("angle beyond a quarter turn");

    // A stalled output holds the pipeline still
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(r_m) && $stable(r_m_valid))
        else $error("pipeline moved while output stalled");

endmodule

// ===== dv/tb_offset_sine_sample_generator_unit.sv =====
module tb_offset_sine_sample_generator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 60;
    localparam int unsigned PHASE_ITEMS = 200;

    typedef struct packed {
        logic [oss_pkg::VAL_W-1:0] value;
        logic                      err;
    } t_sine_result;

    typedef enum logic {ROW_ITEM, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        oss_pkg::t_cfg_index reg_sel;
        int unsigned         arg;
        bit                  typed;
        t_sine_result        res;
    } t_stim_row;

    typedef struct {
        int unsigned amp;
        int unsigned cnt;
        int unsigned send_idle;
        int unsigned recv_stall;
        bit          hold;
    } t_phase;

    // DUT ports; the inputs are all known from time zero
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic                      i_cfg_index = 1'b0;
    logic [oss_pkg::CNT_W-1:0] i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [oss_pkg::IDX_W-1:0] i_sample_index = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [oss_pkg::VAL_W-1:0] o_sample_value;
    logic                      o_index_error;

    // Predictor copy of the registers
    longint unsigned amp_reg = 2048;
    longint unsigned cnt_reg = 100;

    t_sine_result  pending_q[$];
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   hold_left = 0;
    int unsigned   fail_cnt = 0;
    int unsigned   items_sent = 0;
    int unsigned   results_seen = 0;
    int unsigned   err_results = 0;
    int unsigned   quiet_cycles = 0;

    offset_sine_sample_generator_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // |sin| of a quarter-wave fraction, Q30
    function automatic longint unsigned quarter_sine_q30(input longint unsigned frac);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned term;
        longint unsigned m;
        x  = (frac * 64'h6487ED51) >> 22;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 7; k >= 1; k--) begin
            term = ((x2 * t) >> 30) / longint'((2 * k) * (2 * k + 1));
            t = (term >= (64'd1 << 30)) ? 64'd0 : ((64'd1 << 30) - term);
        end
        m = (x * t) >> 30;
        return (m > (64'd1 << 30)) ? (64'd1 << 30) : m;
    endfunction

    function automatic t_sine_result predict_sample(input logic [oss_pkg::IDX_W-1:0] idx);
        t_sine_result    res;
        longint unsigned n;
        longint unsigned phase;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned m;
        longint unsigned num;
        longint unsigned val;
        n = (cnt_reg > oss_pkg::MAX_SAMPLES) ? oss_pkg::MAX_SAMPLES : cnt_reg;
        if (n == 0 || idx >= n) begin
            res.value = '0;
            res.err   = 1'b1;
            return res;
        end
        phase = (longint'(idx) << 24) / n;
        quad  = (phase >> 22) & 3;
        r     = phase & ((64'd1 << 22) - 1);
        m     = quarter_sine_q30((quad == 1 || quad == 3) ? ((64'd1 << 22) - r) : r);
        num   = (quad >= 2) ? ((64'd1 << 30) - m) : ((64'd1 << 30) + m);
        val   = (amp_reg * num) >> 30;
        if (val > oss_pkg::DAC_FULL_SCALE) val = oss_pkg::DAC_FULL_SCALE;
        res.value = val[oss_pkg::VAL_W-1:0];
        res.err   = 1'b0;
        return res;
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checking and watchdog; inputs only move at posedge, so negedge is stable
    always @(negedge i_clk) begin
        t_sine_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_index_error) err_results++;
            if (pending_q.size() == 0) begin
                $error("unexpected result: value %0d err %0b", o_sample_value, o_index_error);
                fail_cnt++;
            end else begin
                exp_res = pending_q.pop_front();
                if (o_sample_value !== exp_res.value) begin
                    $error("sample_value: expected %0d, got %0d", exp_res.value,
                           o_sample_value);
                    fail_cnt++;
                end
                if (o_index_error !== exp_res.err) begin
                    $error("index_error: expected %0b, got %0b", exp_res.err,
                           o_index_error);
                    fail_cnt++;
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one item and wait for its acceptance; called at a rising edge
    task automatic send_sample(input logic [oss_pkg::IDX_W-1:0] idx, input bit typed,
                               input t_sine_result typed_res);
        bit acc;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_sample_index <= idx;
        do begin
            @(negedge i_clk);
            acc = o_in_ready;
            @(posedge i_clk);
        end while (!acc);
        pending_q.push_back(typed ? typed_res : predict_sample(idx));
        items_sent++;
    endtask

    // Stop offering and wait until every expected result is back
    task automatic drain(input int unsigned extra);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // One register write, after which the write port is left quiet before the task returns
    task automatic write_reg(input oss_pkg::t_cfg_index sel, input int unsigned data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data[oss_pkg::CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (sel == oss_pkg::CFG_AMPLITUDE) amp_reg = data & 12'hFFF;
        else cnt_reg = data & 13'h1FFF;
        @(posedge i_clk);
    endtask

    // Directed rows: crest, trough, zero crossings, out of period, register extremes
    t_stim_row dir_rows[27] = '{
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    0,    1, '{12'd2048, 1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    25,   1, '{12'd4095, 1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    50,   1, '{12'd2048, 1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    75,   1, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    99,   0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    100,  1, '{12'd0,    1'b1}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    4095, 1, '{12'd0,    1'b1}},
        '{ROW_WRITE, oss_pkg::CFG_AMPLITUDE,    0,    0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    37,   1, '{12'd0,    1'b0}},
        '{ROW_WRITE, oss_pkg::CFG_SAMPLE_COUNT, 1,    0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    0,    1, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    1,    1, '{12'd0,    1'b1}},
        '{ROW_WRITE, oss_pkg::CFG_AMPLITUDE,    4095, 0, '{12'd0,    1'b0}},
        '{ROW_WRITE, oss_pkg::CFG_SAMPLE_COUNT, 0,    0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    0,    1, '{12'd0,    1'b1}},
        '{ROW_WRITE, oss_pkg::CFG_SAMPLE_COUNT, 4096, 0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    4095, 0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    1024, 1, '{12'd4095, 1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    2048, 0, '{12'd0,    1'b0}},
        '{ROW_WRITE, oss_pkg::CFG_SAMPLE_COUNT, 8191, 0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    4095, 0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    3072, 0, '{12'd0,    1'b0}},
        '{ROW_WRITE, oss_pkg::CFG_SAMPLE_COUNT, 4,    0, '{12'd0,    1'b0}},
        '{ROW_WRITE, oss_pkg::CFG_AMPLITUDE,    1,    0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    1,    0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    3,    0, '{12'd0,    1'b0}},
        '{ROW_ITEM,  oss_pkg::CFG_AMPLITUDE,    2730, 1, '{12'd0,    1'b1}}
    };

    // Random phases: register settings and idling modes
    t_phase phases[8] = '{
        '{2048, 100,  0,  0,  0},
        '{1000, 4096, 49, 0,  0},
        '{2048, 4096, 0,  0,  1},
        '{4095, 37,   0,  49, 0},
        '{0,    2,    22, 22, 0},
        '{1234, 8191, 22, 22, 0},
        '{0,    0,    22, 22, 0},
        '{2048, 4096, 0,  49, 0}
    };

    initial begin
        int unsigned               n_eff;
        logic [oss_pkg::IDX_W-1:0] idx;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, default registers first
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                drain(4);
                write_reg(dir_rows[i].reg_sel, dir_rows[i].arg);
            end else begin
                send_sample(dir_rows[i].arg[oss_pkg::IDX_W-1:0], dir_rows[i].typed,
                            dir_rows[i].res);
            end
        end

        // Random part; the phase with zero settings draws its registers at random
        foreach (phases[p]) begin
            drain(4);
            if (p == 6) begin
                phases[p].amp = $urandom_range(4095);
                phases[p].cnt = $urandom_range(4096, 1);
            end
            write_reg(oss_pkg::CFG_AMPLITUDE, phases[p].amp);
            write_reg(oss_pkg::CFG_SAMPLE_COUNT, phases[p].cnt);
            send_idle_pct  = phases[p].send_idle;
            recv_stall_pct = phases[p].recv_stall;
            if (phases[p].hold) hold_left = HOLD_CYCLES;
            n_eff = (phases[p].cnt > oss_pkg::MAX_SAMPLES) ? oss_pkg::MAX_SAMPLES
                                                           : phases[p].cnt;
            repeat (PHASE_ITEMS) begin
                if (n_eff > 0 && $urandom_range(99) < 85)
                    idx = oss_pkg::IDX_W'($urandom_range(n_eff - 1));
                else
                    idx = oss_pkg::IDX_W'($urandom_range(4095));
                send_sample(idx, 1'b0, '0);
            end
        end

        drain(TAIL_CYCLES);
        $display("covered %0d items over %0d register settings with mixed idling",
                 items_sent, $size(phases) + 6);
        $display("results checked: %0d, of them %0d index errors", results_seen,
                 err_results);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
